FILE: hdl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Word types for both channels, fixed-point constants and sector codes that
// the conversion pipeline shares.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // Default number of fraction bits in the internal color values.
    localparam int FRAC_BITS_DEF = 20;

    // Port field widths.
    localparam int HUE_W  = 16;
    localparam int PCT_W  = 12;
    localparam int CHAN_W = 8;

    // Input ranges: hue in 1/64 degree, saturation and value in 1/16 percent.
    localparam int HUE_FULL   = 23040;
    localparam int HUE_SECTOR = 3840;
    localparam int HUE_PERIOD = 7680;
    localparam int PCT_FULL   = 1600;

    // Internal widths of checked, unsigned values.
    localparam int HU_W = 15;   // hue 0..23040
    localparam int PU_W = 11;   // saturation or value 0..1600
    localparam int T_W  = 13;   // hue within a 120 degree period, 0..7680
    localparam int W_W  = 12;   // distance to the sector border, 0..3840
    localparam int P_W  = 22;   // s * v, 0..2560000

    // Value scaling: v * 2^F / 1600 = v * 2^(F-6) / 25, split as v = 25 * a + b.
    localparam int VF_DIV   = 25;
    localparam int AV_SHIFT = 16;
    localparam int AVR_W    = 12;
    localparam int AV_W     = 7;
    localparam int BV_W     = 5;
    localparam logic [AVR_W-1:0] AV_RECIP =
        AVR_W'(((64'd1 << AV_SHIFT) + VF_DIV - 1) / VF_DIV);

    // Chroma scaling: s * v * 2^F / 2560000 = p * 2^(F-12) / 625, split as
    // p = 625 * q + r.
    localparam int C_DIV   = 625;
    localparam int Q_SHIFT = 32;
    localparam int QR_W    = 23;
    localparam int Q_W     = 13;
    localparam int R_W     = 10;
    localparam int R_SHIFT = 20;
    localparam logic [QR_W-1:0] Q_RECIP =
        QR_W'(((64'd1 << Q_SHIFT) + C_DIV - 1) / C_DIV);

    // Secondary component: C * w / 3840 = ((C * w) >> 8) / 15.
    localparam int X_SHIFT = 8;
    localparam int Z_DIV   = 15;
    localparam int Z_LOG   = 4;
    localparam int L_W     = 16;
    localparam int Z_W     = 20;
    localparam int Z_SHIFT = Z_W + Z_LOG;
    localparam int ZR_W    = 21;
    localparam int ZQ_W    = 17;
    localparam logic [ZR_W-1:0] Z_RECIP =
        ZR_W'(((64'd1 << Z_SHIFT) + Z_DIV - 1) / Z_DIV);

    // Pipeline depth.
    localparam int NUM_STAGES = 12;

    // The six 60 degree hue sectors.
    localparam logic [2:0] SEC_RY = 3'd0;   // red to yellow
    localparam logic [2:0] SEC_YG = 3'd1;   // yellow to green
    localparam logic [2:0] SEC_GC = 3'd2;   // green to cyan
    localparam logic [2:0] SEC_CB = 3'd3;   // cyan to blue
    localparam logic [2:0] SEC_BM = 3'd4;   // blue to magenta
    localparam logic [2:0] SEC_MR = 3'd5;   // magenta to red

    // Input word: one HSV color.
    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic signed [PCT_W-1:0] saturation;
        logic signed [PCT_W-1:0] brightness;
    } t_hsv_word;

    // Output word: one RGB color and the range flag.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              invalid;
    } t_rgb_word;

endpackage

FILE: hdl/hsv_to_rgb_converter_core.sv
// An accepted input word passes through every stage register on its way to the output word.
// Throughput: one word per clock while i_stall is low; a new word may enter on every cycle that o_stall is low.
// The depth comes from the chain of reciprocal multiplies for the constant
// divisions by 625 and 15, each followed by its correction stage.
// Reset clears the valid bits of all twelve stages; data registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Converts one HSV color per clock into 8-bit red, green and blue channels in
// a twelve-stage fixed-point pipeline with per-stage valid and backpressure.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  hsvrgb_pkg::t_hsv_word i_hsv,
    output logic                  o_valid,
    input  logic                  i_stall,
    output hsvrgb_pkg::t_rgb_word o_rgb
);
    import hsvrgb_pkg::*;

    // Widths that follow from the fraction size.
    localparam int K1   = FRAC_BITS - 12;     // chroma shift after the /625 split
    localparam int K2   = FRAC_BITS - 6;      // value shift after the /25 split
    localparam int VW   = FRAC_BITS + 1;      // fraction values 0..2^F
    localparam int RFW  = K1 + 1;
    localparam int A1W  = K1 + 11;
    localparam int R1PW = R_W + A1W;
    localparam int YW   = FRAC_BITS + 5;
    localparam int HW   = YW - L_W;
    localparam int AHW  = HW + 1;
    localparam int HPW  = 2 * HW + 4;
    localparam int SW   = VW + CHAN_W;

    localparam logic [A1W-1:0] R_RECIP =
        A1W'(((64'd1 << (R_SHIFT + K1)) + C_DIV - 1) / C_DIV);
    localparam logic [AHW-1:0] H_RECIP =
        AHW'(((64'd1 << (HW + Z_LOG)) + Z_DIV - 1) / Z_DIV);

    // Scale a fraction of 2^F to a channel: floor(val * 255 / 2^F).
    function automatic logic [CHAN_W-1:0] to_chan(input logic [VW-1:0] val);
        logic [SW-1:0] scaled;
        scaled = (SW'(val) << CHAN_W) - SW'(val);
        return scaled[FRAC_BITS +: CHAN_W];
    endfunction

    // Table of floor(b * 2^(F-6) / 25) for the value remainder b.
    logic [K2-1:0] w_vf_frac_tbl [VF_DIV];
    for (genvar gi = 0; gi < VF_DIV; gi++) begin : g_vf_tbl
        localparam logic [K2-1:0] TV = K2'((64'(gi) << K2) / VF_DIV);
        assign w_vf_frac_tbl[gi] = TV;
    end

    // ------------------------------------------------------------------
    // Handshake: a stage loads a valid input when it is empty or its successor is ready.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;
    logic [NUM_STAGES-1:0] w_vin;
    logic [NUM_STAGES-1:0] w_ld;

    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    assign w_vin = {r_vld[NUM_STAGES-2:0], i_valid};
    assign w_ld  = w_rdy & w_vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_rdy) | (w_vin & w_rdy);
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: range check, hue sector and border distance, s * v, v / 25.
    // An out of range word runs through with zeros, which yields black.
    // ------------------------------------------------------------------
    logic                      w_bad;
    logic [HU_W-1:0]           w_hu;
    logic [PU_W-1:0]           w_s;
    logic [PU_W-1:0]           w_v;
    logic [HU_W-1:0]           w_base;
    logic [T_W-1:0]            w_t;
    logic [PU_W+AVR_W-1:0]     w_avprod;
    logic [2:0]                n_s1_sec;
    logic [W_W-1:0]            n_s1_w;
    logic                      r_s1_inv;
    logic [2:0]                r_s1_sec;
    logic [W_W-1:0]            r_s1_w;
    logic [P_W-1:0]            r_s1_p;
    logic [AV_W-1:0]           r_s1_av;
    logic [PU_W-1:0]           r_s1_v;

    always_comb begin
        w_bad = i_hsv.hue[HUE_W-1] || (i_hsv.hue > HUE_W'(HUE_FULL))
             || i_hsv.saturation[PCT_W-1] || (i_hsv.saturation > PCT_W'(PCT_FULL))
             || i_hsv.brightness[PCT_W-1] || (i_hsv.brightness > PCT_W'(PCT_FULL));
        w_hu = w_bad ? '0 : i_hsv.hue[HU_W-1:0];
        w_s  = w_bad ? '0 : i_hsv.saturation[PU_W-1:0];
        w_v  = w_bad ? '0 : i_hsv.brightness[PU_W-1:0];

        // Full circle of 360 degrees falls into the last sector.
        priority if (w_hu >= HU_W'(5 * HUE_SECTOR)) begin
            n_s1_sec = SEC_MR;
        end else if (w_hu >= HU_W'(4 * HUE_SECTOR)) begin
            n_s1_sec = SEC_BM;
        end else if (w_hu >= HU_W'(3 * HUE_SECTOR)) begin
            n_s1_sec = SEC_CB;
        end else if (w_hu >= HU_W'(2 * HUE_SECTOR)) begin
            n_s1_sec = SEC_GC;
        end else if (w_hu >= HU_W'(HUE_SECTOR)) begin
            n_s1_sec = SEC_YG;
        end else begin
            n_s1_sec = SEC_RY;
        end

        unique case (n_s1_sec)
            SEC_RY, SEC_YG: begin
                w_base = '0;
            end
            SEC_GC, SEC_CB: begin
                w_base = HU_W'(HUE_PERIOD);
            end
            default: begin
                w_base = HU_W'(2 * HUE_PERIOD);
            end
        endcase

        w_t = T_W'(w_hu - w_base);
        if (w_t >= T_W'(HUE_SECTOR)) begin
            n_s1_w = W_W'(T_W'(HUE_PERIOD) - w_t);
        end else begin
            n_s1_w = W_W'(w_t);
        end

        w_avprod = (PU_W + AVR_W)'(w_v) * (PU_W + AVR_W)'(AV_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s1_inv <= w_bad;
            r_s1_sec <= n_s1_sec;
            r_s1_w   <= n_s1_w;
            r_s1_p   <= P_W'(w_s) * P_W'(w_v);
            r_s1_av  <= w_avprod[AV_SHIFT +: AV_W];
            r_s1_v   <= w_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: estimate p / 625, finish the scaled value Vf.
    // ------------------------------------------------------------------
    logic [P_W+QR_W-1:0] w_qprod;
    logic [PU_W-1:0]     w_av25;
    logic [BV_W-1:0]     w_bv;
    logic                r_s2_inv;
    logic [2:0]          r_s2_sec;
    logic [W_W-1:0]      r_s2_w;
    logic [P_W-1:0]      r_s2_p;
    logic [Q_W-1:0]      r_s2_q;
    logic [VW-1:0]       r_s2_vf;

    assign w_qprod = (P_W + QR_W)'(r_s1_p) * (P_W + QR_W)'(Q_RECIP);
    assign w_av25  = PU_W'(r_s1_av) * PU_W'(VF_DIV);
    assign w_bv    = BV_W'(r_s1_v - w_av25);

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_s2_inv <= r_s1_inv;
            r_s2_sec <= r_s1_sec;
            r_s2_w   <= r_s1_w;
            r_s2_p   <= r_s1_p;
            r_s2_q   <= w_qprod[Q_SHIFT +: Q_W];
            r_s2_vf  <= (VW'(r_s1_av) << K2) + VW'(w_vf_frac_tbl[w_bv]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: remainder of p / 625.
    // ------------------------------------------------------------------
    logic           r_s3_inv;
    logic [2:0]     r_s3_sec;
    logic [W_W-1:0] r_s3_w;
    logic [Q_W-1:0] r_s3_q;
    logic [R_W-1:0] r_s3_r;
    logic [VW-1:0]  r_s3_vf;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r_s3_inv <= r_s2_inv;
            r_s3_sec <= r_s2_sec;
            r_s3_w   <= r_s2_w;
            r_s3_q   <= r_s2_q;
            r_s3_r   <= R_W'(r_s2_p - P_W'(r_s2_q) * P_W'(C_DIV));
            r_s3_vf  <= r_s2_vf;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: fraction part of chroma, floor(r * 2^(F-12) / 625).
    // ------------------------------------------------------------------
    logic [R1PW-1:0] w_rprod;
    logic            r_s4_inv;
    logic [2:0]      r_s4_sec;
    logic [W_W-1:0]  r_s4_w;
    logic [Q_W-1:0]  r_s4_q;
    logic [RFW-1:0]  r_s4_rf;
    logic [VW-1:0]   r_s4_vf;

    assign w_rprod = R1PW'(r_s3_r) * R1PW'(R_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_s4_inv <= r_s3_inv;
            r_s4_sec <= r_s3_sec;
            r_s4_w   <= r_s3_w;
            r_s4_q   <= r_s3_q;
            r_s4_rf  <= w_rprod[R_SHIFT +: RFW];
            r_s4_vf  <= r_s3_vf;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: assemble chroma C.
    // ------------------------------------------------------------------
    logic           r_s5_inv;
    logic [2:0]     r_s5_sec;
    logic [W_W-1:0] r_s5_w;
    logic [VW-1:0]  r_s5_c;
    logic [VW-1:0]  r_s5_vf;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_s5_inv <= r_s4_inv;
            r_s5_sec <= r_s4_sec;
            r_s5_w   <= r_s4_w;
            r_s5_c   <= (VW'(r_s4_q) << K1) + VW'(r_s4_rf);
            r_s5_vf  <= r_s4_vf;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: C * w / 256 and the offset m = Vf - C.
    // ------------------------------------------------------------------
    logic [VW+W_W-1:0] w_cw;
    logic              r_s6_inv;
    logic [2:0]        r_s6_sec;
    logic [VW-1:0]     r_s6_c;
    logic [VW-1:0]     r_s6_m;
    logic [YW-1:0]     r_s6_y;

    assign w_cw = (VW + W_W)'(r_s5_c) * (VW + W_W)'(r_s5_w);

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r_s6_inv <= r_s5_inv;
            r_s6_sec <= r_s5_sec;
            r_s6_c   <= r_s5_c;
            r_s6_m   <= r_s5_vf - r_s5_c;
            r_s6_y   <= YW'(w_cw >> X_SHIFT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: divide the upper part of y by 15.
    // ------------------------------------------------------------------
    logic [HPW-1:0] w_hprod;
    logic           r_s7_inv;
    logic [2:0]     r_s7_sec;
    logic [VW-1:0]  r_s7_c;
    logic [VW-1:0]  r_s7_m;
    logic [HW-1:0]  r_s7_h;
    logic [HW-1:0]  r_s7_hq;
    logic [L_W-1:0] r_s7_l;

    assign w_hprod = HPW'(r_s6_y[YW-1:L_W]) * HPW'(H_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_ld[6]) begin
            r_s7_inv <= r_s6_inv;
            r_s7_sec <= r_s6_sec;
            r_s7_c   <= r_s6_c;
            r_s7_m   <= r_s6_m;
            r_s7_h   <= r_s6_y[YW-1:L_W];
            r_s7_hq  <= w_hprod[HW + Z_LOG +: HW];
            r_s7_l   <= r_s6_y[L_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: carry the upper remainder into the lower part.
    // ------------------------------------------------------------------
    logic [HW+Z_LOG-1:0] w_hr_full;
    logic                r_s8_inv;
    logic [2:0]          r_s8_sec;
    logic [VW-1:0]       r_s8_c;
    logic [VW-1:0]       r_s8_m;
    logic [HW-1:0]       r_s8_hq;
    logic [Z_W-1:0]      r_s8_z;

    assign w_hr_full = (HW + Z_LOG)'(r_s7_h) - ((HW + Z_LOG)'(r_s7_hq) << Z_LOG)
                     + (HW + Z_LOG)'(r_s7_hq);

    always_ff @(posedge i_clk) begin
        if (w_ld[7]) begin
            r_s8_inv <= r_s7_inv;
            r_s8_sec <= r_s7_sec;
            r_s8_c   <= r_s7_c;
            r_s8_m   <= r_s7_m;
            r_s8_hq  <= r_s7_hq;
            r_s8_z   <= {w_hr_full[Z_LOG-1:0], r_s7_l};
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: divide the lower part by 15.
    // ------------------------------------------------------------------
    logic [Z_W+ZR_W-1:0] w_zprod;
    logic                r_s9_inv;
    logic [2:0]          r_s9_sec;
    logic [VW-1:0]       r_s9_c;
    logic [VW-1:0]       r_s9_m;
    logic [HW-1:0]       r_s9_hq;
    logic [ZQ_W-1:0]     r_s9_zq;

    assign w_zprod = (Z_W + ZR_W)'(r_s8_z) * (Z_W + ZR_W)'(Z_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_ld[8]) begin
            r_s9_inv <= r_s8_inv;
            r_s9_sec <= r_s8_sec;
            r_s9_c   <= r_s8_c;
            r_s9_m   <= r_s8_m;
            r_s9_hq  <= r_s8_hq;
            r_s9_zq  <= w_zprod[Z_SHIFT +: ZQ_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: assemble the secondary component X.
    // ------------------------------------------------------------------
    logic          r_s10_inv;
    logic [2:0]    r_s10_sec;
    logic [VW-1:0] r_s10_c;
    logic [VW-1:0] r_s10_m;
    logic [VW-1:0] r_s10_x;

    always_ff @(posedge i_clk) begin
        if (w_ld[9]) begin
            r_s10_inv <= r_s9_inv;
            r_s10_sec <= r_s9_sec;
            r_s10_c   <= r_s9_c;
            r_s10_m   <= r_s9_m;
            r_s10_x   <= VW'((YW'(r_s9_hq) << L_W) + YW'(r_s9_zq));
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: place C, X and zero by sector and add the offset.
    // ------------------------------------------------------------------
    logic [VW-1:0] w_cr;
    logic [VW-1:0] w_cg;
    logic [VW-1:0] w_cb;
    logic          r_s11_inv;
    logic [VW-1:0] r_s11_m;
    logic [VW-1:0] r_s11_r;
    logic [VW-1:0] r_s11_g;
    logic [VW-1:0] r_s11_b;

    always_comb begin
        unique case (r_s10_sec)
            SEC_RY: begin
                w_cr = r_s10_c;
                w_cg = r_s10_x;
                w_cb = '0;
            end
            SEC_YG: begin
                w_cr = r_s10_x;
                w_cg = r_s10_c;
                w_cb = '0;
            end
            SEC_GC: begin
                w_cr = '0;
                w_cg = r_s10_c;
                w_cb = r_s10_x;
            end
            SEC_CB: begin
                w_cr = '0;
                w_cg = r_s10_x;
                w_cb = r_s10_c;
            end
            SEC_BM: begin
                w_cr = r_s10_x;
                w_cg = '0;
                w_cb = r_s10_c;
            end
            default: begin
                w_cr = r_s10_c;
                w_cg = '0;
                w_cb = r_s10_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[10]) begin
            r_s11_inv <= r_s10_inv;
            r_s11_m   <= r_s10_m;
            r_s11_r   <= w_cr + r_s10_m;
            r_s11_g   <= w_cg + r_s10_m;
            r_s11_b   <= w_cb + r_s10_m;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: scale to 8-bit channels; this is the output register.
    // ------------------------------------------------------------------
    t_rgb_word r_s12_word;

    always_ff @(posedge i_clk) begin
        if (w_ld[11]) begin
            r_s12_word.red     <= to_chan(r_s11_r);
            r_s12_word.green   <= to_chan(r_s11_g);
            r_s12_word.blue    <= to_chan(r_s11_b);
            r_s12_word.invalid <= r_s11_inv;
        end
    end

    assign o_rgb = r_s12_word;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The input side stalls only when every stage holds a word.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a pipeline stage was empty");

    // The secondary component never exceeds chroma.
    a_x_within_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[9] |-> (r_s10_x <= r_s10_c))
        else $error("secondary component larger than chroma");

    // One channel always carries the bare offset.
    a_one_channel_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[10] |-> (r_s11_r == r_s11_m || r_s11_g == r_s11_m || r_s11_b == r_s11_m))
        else $error("no channel equals the offset");

    // An out of range color comes out black.
    a_invalid_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rgb.invalid) |->
            (o_rgb.red == '0 && o_rgb.green == '0 && o_rgb.blue == '0))
        else $error("invalid word with nonzero channels");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
